// ----- hw/rtl/bpa_pkg.sv -----
// bpa_pkg: shared types and constants for the buddy page allocator
// no dependencies
`default_nettype none
package bpa_pkg;
  localparam int MinOrderBits = 12;
  localparam int MaxOrderBits = 20;
  localparam int Nord = MaxOrderBits - MinOrderBits;
  localparam int Npages = 1 << Nord;
  localparam int PageW = 8;
  localparam int OrdW = 4;
  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree = 1'b1;

  typedef struct packed {
    logic        action;
    logic [20:0] req_size;
    logic [7:0]  free_page;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] page_index;
    logic [3:0] block_order;
  } rsp_t;

  typedef struct packed {
    logic [3:0] ord;
    logic       is_free;
    logic       is_alloc;
  } pinfo_t;
endpackage
`default_nettype wire

// ----- hw/rtl/bpa_ram.sv -----
// bpa_ram: 256 x 8 link memory, one write port, one registered read port
// no dependencies
`default_nettype none
module bpa_ram (
  input  wire logic       clk,
  input  wire logic       we,
  input  wire logic [7:0] waddr,
  input  wire logic [7:0] wdata,
  input  wire logic [7:0] raddr,
  output logic      [7:0] rdata
);
  logic [7:0] mem [256];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/buddy_page_allocator.sv -----
// buddy_page_allocator: 256-page buddy allocator, free lists in link memories
// an alloc splits a block at most eight times, a free merges at most eight times
// throughput: one request at a time, next word accepted in the strobe cycle at the earliest
// reset: synchronous, then a page table clearing pass over all 256 pages with busy high;
// page 0 ends as one free top-order block; results cannot be stalled
// depends on bpa_pkg, bpa_ram
`default_nettype none
module buddy_page_allocator (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire bpa_pkg::req_t req,
  output logic               busy,
  output logic               done,
  output bpa_pkg::rsp_t      rsp
);
  import bpa_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0, S_FIND = 5'd1, S_SPLCHK = 5'd2,
    S_RM0 = 5'd3, S_RM1 = 5'd4, S_RM2 = 5'd5, S_PU0 = 5'd6, S_PU1 = 5'd7,
    S_DISP = 5'd8, S_GRANT = 5'd9, S_MCHK = 5'd10, S_OUT = 5'd11,
    S_FCHK = 5'd12, S_CLR = 5'd13;
  localparam logic [2:0] K_SPLIT = 3'd0, K_SPL_L = 3'd1, K_SPL_B = 3'd2,
    K_GRANT = 3'd3, K_FREE = 3'd4, K_MRG_P = 3'd5, K_MRG_B = 3'd6, K_MRG_U = 3'd7;

  logic [4:0] state;
  logic [2:0] kind;
  logic [7:0] head [9];
  logic [7:0] tail [9];
  logic [8:0] nonempty;
  logic [20:0] size;
  logic [3:0] ord;
  logic [7:0] pg, bud;
  logic [7:0] lp, ln;
  logic [7:0] op_p;
  logic       op_tail;

  logic       nwe, pwe;
  logic [7:0] nwa, nwd, nra, nrd, pwa, pwd, pra, prd;

  // page table: order, free and allocated flags per page
  pinfo_t     pinfo [256];
  logic       iwe;
  logic [7:0] iwa, ira;
  pinfo_t     iwd, ird;

  bpa_ram u_next (.clk, .we(nwe), .waddr(nwa), .wdata(nwd), .raddr(nra), .rdata(nrd));
  bpa_ram u_prev (.clk, .we(pwe), .waddr(pwa), .wdata(pwd), .raddr(pra), .rdata(prd));

  always_ff @(posedge clk) begin
    if (iwe) pinfo[iwa] <= iwd;
    ird <= pinfo[ira];
  end

  logic [21:0] blk;
  assign blk = 22'(1) << (5'(ord) + 5'(MinOrderBits));
  logic [7:0] obit;
  assign obit = 8'(9'(1) << ord);

  assign busy = state != S_IDLE;

  // ram ports driven from state
  always_comb begin
    nwe = 1'b0; pwe = 1'b0;
    nwa = '0; nwd = '0; pwa = '0; pwd = '0;
    nra = op_p; pra = op_p;
    iwe = 1'b0; iwa = op_p; iwd = '0; ira = op_p;
    case (state)
      S_IDLE: ira = req.free_page;
      S_CLR: begin
        iwe = 1'b1; iwa = pg;
        if (pg == 8'd0) begin
          iwd.ord = 4'(Nord); iwd.is_free = 1'b1;
        end
      end
      S_RM2: begin
        if (!(head[ord] == op_p) && !(tail[ord] == op_p)) begin
          nwe = 1'b1; nwa = lp; nwd = ln;
          pwe = 1'b1; pwa = ln; pwd = lp;
        end
        iwe = 1'b1; iwd.ord = ord;
      end
      S_PU0: begin
        if (nonempty[ord] && op_tail) begin
          pwe = 1'b1; pwa = op_p; pwd = tail[ord];
          nwe = 1'b1; nwa = tail[ord]; nwd = op_p;
        end else if (nonempty[ord]) begin
          nwe = 1'b1; nwa = op_p; nwd = head[ord];
          pwe = 1'b1; pwa = head[ord]; pwd = op_p;
        end
        iwe = 1'b1; iwd.ord = ord; iwd.is_free = 1'b1;
      end
      S_DISP: ira = pg ^ obit;
      S_GRANT: begin
        iwe = 1'b1; iwa = pg; iwd.ord = ord; iwd.is_alloc = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      done <= 1'b0;
      pg <= '0;
      nonempty <= 9'h100;
      for (int i = 0; i < 9; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_CLR: begin
          pg <= pg + 8'd1;
          if (pg == 8'd255) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            size <= req.req_size;
            pg <= req.free_page;
            ord <= '0;
            rsp <= '0;
            if (req.action == ActAlloc) state <= S_FIND;
            else state <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (ird.is_alloc) begin
            ord <= (ird.ord > 4'(Nord)) ? 4'(Nord) : ird.ord;
            op_p <= pg; op_tail <= 1'b0; kind <= K_FREE;
            rsp.ok <= 1'b1;
            state <= S_PU0;
          end else state <= S_OUT;
        end
        S_FIND: begin
          if (nonempty[ord] && 22'(size) <= blk) state <= S_SPLCHK;
          else if (ord == 4'(Nord)) state <= S_OUT;
          else ord <= ord + 4'd1;
        end
        S_SPLCHK: begin
          op_p <= head[ord];
          pg <= head[ord];
          if (ord != 0 && blk >= {size, 1'b0}) kind <= K_SPLIT;
          else kind <= K_GRANT;
          state <= S_RM0;
        end
        S_RM0: state <= S_RM1;
        S_RM1: begin
          ln <= nrd; lp <= prd;
          state <= S_RM2;
        end
        S_RM2: begin
          if (head[ord] == op_p && tail[ord] == op_p) nonempty[ord] <= 1'b0;
          else if (head[ord] == op_p) head[ord] <= ln;
          else if (tail[ord] == op_p) tail[ord] <= lp;
          state <= S_DISP;
        end
        S_PU0: begin
          if (!nonempty[ord]) begin
            head[ord] <= op_p; tail[ord] <= op_p; nonempty[ord] <= 1'b1;
          end else if (op_tail) tail[ord] <= op_p;
          else head[ord] <= op_p;
          state <= S_DISP;
        end
        S_DISP: begin
          case (kind)
            K_SPLIT: begin
              ord <= ord - 4'd1;
              op_p <= pg; op_tail <= 1'b0; kind <= K_SPL_L;
              bud <= pg ^ 8'(9'(1) << (ord - 4'd1));
              state <= S_PU0;
            end
            K_SPL_L: begin
              op_p <= bud; op_tail <= 1'b1; kind <= K_SPL_B;
              state <= S_PU0;
            end
            K_SPL_B: state <= S_SPLCHK;
            K_GRANT: state <= S_GRANT;
            K_FREE, K_MRG_U: begin
              bud <= pg ^ obit;
              state <= S_MCHK;
            end
            K_MRG_P: begin
              op_p <= bud; kind <= K_MRG_B;
              state <= S_RM0;
            end
            default: begin
              pg <= (pg < bud) ? pg : bud;
              op_p <= (pg < bud) ? pg : bud;
              op_tail <= 1'b1;
              ord <= ord + 4'd1;
              kind <= K_MRG_U;
              state <= S_PU0;
            end
          endcase
        end
        S_MCHK: begin
          if (ord < 4'(Nord) && ird.is_free && ird.ord == ord) begin
            op_p <= pg; kind <= K_MRG_P;
            state <= S_RM0;
          end else state <= S_OUT;
        end
        S_GRANT: begin
          rsp.ok <= 1'b1;
          rsp.page_index <= pg;
          rsp.block_order <= ord;
          state <= S_OUT;
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- tb/tb_buddy_page_allocator.sv -----
// tb_buddy_page_allocator: self-checking bench for the buddy page allocator
// drives alloc and free words, predicts grants with its own free-list model
// depends on bpa_pkg and buddy_page_allocator
`default_nettype none
module tb_buddy_page_allocator;
  import bpa_pkg::*;

  class alloc_scoreboard;
    bit          free_flag[Npages];
    logic [3:0]  ord_of[Npages];
    bit          granted[Npages];
    logic [7:0]  nxt[Npages];
    logic [7:0]  prv[Npages];
    logic [7:0]  head[Nord+1];
    logic [7:0]  tail[Nord+1];
    bit          nonempty[Nord+1];
    rsp_t        pending[$];
    int          errors;
    int          checked;

    function new();
      for (int i = 0; i < Npages; i++) begin
        free_flag[i] = 0; ord_of[i] = 0; granted[i] = 0; nxt[i] = 0; prv[i] = 0;
      end
      for (int o = 0; o <= Nord; o++) begin
        head[o] = 0; tail[o] = 0; nonempty[o] = 0;
      end
      free_flag[0] = 1;
      ord_of[0] = 4'(Nord);
      nonempty[Nord] = 1;
    endfunction

    function void unlink(int o, logic [7:0] p);
      if (head[o] == p && tail[o] == p) nonempty[o] = 0;
      else if (head[o] == p) head[o] = nxt[p];
      else if (tail[o] == p) tail[o] = prv[p];
      else begin
        nxt[prv[p]] = nxt[p];
        prv[nxt[p]] = prv[p];
      end
      free_flag[p] = 0;
    endfunction

    function void link(int o, logic [7:0] p, bit at_tail);
      if (!nonempty[o]) begin
        head[o] = p; tail[o] = p; nonempty[o] = 1;
      end else if (at_tail) begin
        prv[p] = tail[o]; nxt[tail[o]] = p; tail[o] = p;
      end else begin
        nxt[p] = head[o]; prv[head[o]] = p; head[o] = p;
      end
      free_flag[p] = 1;
      ord_of[p] = 4'(o);
    endfunction

    function void note(req_t r);
      rsp_t e;
      int o;
      bit found;
      logic [7:0] p, b, lo;
      longint sz;
      e = '0;
      sz = r.req_size;
      found = 0;
      if (r.action == ActAlloc) begin
        for (o = 0; o <= Nord; o++)
          if (nonempty[o] && (64'd1 << (o + MinOrderBits)) >= sz) begin
            found = 1;
            break;
          end
        if (found) begin
          while (o > 0 && (64'd1 << (o + MinOrderBits)) >= 2 * sz) begin
            p = head[o];
            b = p ^ (8'd1 << (o - 1));
            unlink(o, p);
            link(o - 1, p, 0);
            link(o - 1, b, 1);
            o--;
          end
          p = head[o];
          unlink(o, p);
          granted[p] = 1;
          e.ok = 1; e.page_index = p; e.block_order = 4'(o);
        end
      end else begin
        p = r.free_page;
        if (granted[p]) begin
          granted[p] = 0;
          o = ord_of[p];
          if (o > Nord) o = Nord;
          link(o, p, 0);
          while (o < Nord) begin
            b = p ^ (8'd1 << o);
            if (!free_flag[b] || ord_of[b] != o) break;
            unlink(o, p);
            unlink(o, b);
            lo = (p < b) ? p : b;
            o++;
            link(o, lo, 1);
            p = lo;
          end
          e.ok = 1;
        end
      end
      pending.push_back(e);
    endfunction

    task check(rsp_t got);
      rsp_t e;
      checked++;
      if (pending.size() == 0) begin
        report("unexpected result word");
        return;
      end
      e = pending.pop_front();
      if (got.ok !== e.ok) report($sformatf("ok got %0b exp %0b", got.ok, e.ok));
      if (got.page_index !== e.page_index)
        report($sformatf("page_index got %0d exp %0d", got.page_index, e.page_index));
      if (got.block_order !== e.block_order)
        report($sformatf("block_order got %0d exp %0d", got.block_order, e.block_order));
    endtask

    task report(string msg);
      errors++;
      if (errors <= 50) $display("error: %s", msg);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  req_t req = '0;
  logic busy, done;
  rsp_t rsp;
  int cycles = 0;
  int n_alloc = 0, n_free = 0;
  logic [7:0] held[$];
  alloc_scoreboard sb = new();

  localparam int Limit = 2000000;

  buddy_page_allocator dut (.clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .rsp(rsp));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check(rsp);
    if (cycles > Limit) begin
      $display("timeout");
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
    repeat (n) @(negedge clk);
  endtask

  task automatic send(bit act, logic [20:0] sz, logic [7:0] pg, bit gap);
    req_t r;
    r.action = act; r.req_size = sz; r.free_page = pg;
    if (gap) idle_gap();
    @(negedge clk);
    while (busy) @(negedge clk);
    start <= 1;
    req <= r;
    @(posedge clk);
    sb.note(r);
    if (act == ActAlloc) n_alloc++; else n_free++;
    @(negedge clk);
    start <= 0;
    req <= 30'($urandom);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic alloc_rand(bit gap);
    logic [20:0] sz;
    int k;
    k = $urandom_range(0, 8);
    sz = (21'd1 << (k + 12)) - 21'($urandom_range(0, (1 << (k + 12)) - 1));
    if ($urandom_range(0, 30) == 0) sz = 21'($urandom);
    send(ActAlloc, sz, 8'($urandom), gap);
    if (sb.pending[$].ok) held.push_back(sb.pending[$].page_index);
  endtask

  task automatic free_rand(bit gap);
    int i;
    logic [7:0] pg;
    if (held.size() != 0 && $urandom_range(0, 9) != 0) begin
      i = $urandom_range(0, held.size() - 1);
      pg = held[i];
      held.delete(i);
    end else pg = 8'($urandom);
    send(ActFree, 21'($urandom), pg, gap);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send(ActAlloc, 21'd1048576, 8'hff, 0);
    send(ActAlloc, 21'd1, 8'h00, 0);
    send(ActFree, 21'h1fffff, 8'd0, 0);
    send(ActFree, 21'd0, 8'd0, 0);
    send(ActAlloc, 21'd0, 8'h00, 0);
    send(ActAlloc, 21'h1fffff, 8'h00, 0);
    send(ActAlloc, 21'd1048577, 8'h00, 0);
    send(ActAlloc, 21'd4097, 8'h00, 0);
    send(ActAlloc, 21'd524288, 8'h00, 0);
    send(ActAlloc, 21'd524288, 8'h00, 0);
    send(ActFree, 21'd0, 8'd128, 0);
    send(ActFree, 21'd0, 8'd1, 0);
    send(ActFree, 21'd0, 8'd2, 0);
    send(ActFree, 21'd0, 8'd0, 0);
    send(ActFree, 21'd0, 8'd2, 0);
    send(ActFree, 21'd0, 8'd255, 0);
    drain();
    for (int i = 0; i < 900; i++) begin
      if (sb.pending.size() == 0 && $urandom_range(0, 60) == 0) drain();
      if ($urandom_range(0, 99) < ((held.size() > 40) ? 35 : 60)) alloc_rand(i % 200 > 40);
      else free_rand(i % 200 > 40);
    end
    while (held.size() != 0) free_rand(1);
    drain();
    $display("%0d allocs and %0d frees sent, %0d result words checked",
      n_alloc, n_free, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
